@@ sv/assert_macros.svh @@
// Assertion helpers shared by the RTL. Each macro checks on the rising edge
// of clock and stays quiet while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition that must hold in the same cycle as its trigger.
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/i2a_pkg.sv @@
package i2a_pkg;

   // Format command codes.
   typedef enum logic {
      CMD_DEC = 1'b0,
      CMD_HEX = 1'b1
   } command_type;

   localparam int VALUE_WIDTH    = 32;
   localparam int DIGITS         = 10;
   localparam int BCD_WIDTH      = 4 * DIGITS;
   localparam int DAB_WIDTH      = BCD_WIDTH + VALUE_WIDTH;
   localparam int DAB_STAGES     = 4;
   localparam int BITS_PER_STAGE = VALUE_WIDTH / DAB_STAGES;
   localparam int POS_WIDTH      = $clog2(DIGITS);
   localparam int CHAR_WIDTH     = 7;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO  = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] ASCII_A     = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] ASCII_MINUS = 7'h2d;

   typedef logic [DAB_WIDTH-1:0] dab_type;
   typedef logic [3:0] digit_type;

   // One double-dabble step: correct every BCD digit of five or more, then
   // shift the combined BCD and binary word left by one bit.
   function automatic dab_type dabble_step(dab_type x);
      dab_type y;
      y = x;
      for (int i = 0; i < DIGITS; i++) begin
         if (y[VALUE_WIDTH + 4*i +: 4] >= 4'd5) begin
            y[VALUE_WIDTH + 4*i +: 4] = y[VALUE_WIDTH + 4*i +: 4] + 4'd3;
         end
      end
      return {y[DAB_WIDTH-2:0], 1'b0};
   endfunction

   // ASCII form of one decimal or hexadecimal digit.
   function automatic logic [CHAR_WIDTH-1:0] digit_char(digit_type d);
      logic [CHAR_WIDTH-1:0] c;
      if (d < 4'd10) begin
         c = ASCII_ZERO + {3'b000, d};
      end else begin
         c = ASCII_A + {3'b000, d - 4'd10};
      end
      return c;
   endfunction

endpackage

@@ sv/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter.
//
// The request channel (req_valid, req_ready, req_command, req_value) takes
// one 32-bit value per transaction. Command decimal prints the value as a
// signed number with a leading minus sign when negative; command hex prints
// it unsigned in lower-case hexadecimal. The response channel (rsp_valid,
// rsp_ready, rsp_character, rsp_last) returns one ASCII character per
// transaction, most significant first, with rsp_last on the final one.
//
// The first character of a value is offered after the request has passed
// through the sign stage, four binary-to-BCD stages and the serializer.
// A value holds the serializer until its last character is taken, and the
// next value loads as that one leaves, so the output port sets the sustained
// rate; the stages ahead of it keep up to five more values in flight.
// Reset clears all valid bits; no output is pending afterwards. When the
// receiver holds rsp_ready low, the current character stays on the port and
// the stages fill up behind it until req_ready drops; nothing is lost.
module integer_to_ascii_formatter
   import i2a_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_command,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [CHAR_WIDTH-1:0]  rsp_character,
   output logic                   rsp_last
);

   // Sign stage.
   logic                   s0_valid_ff;
   logic                   s0_hex_ff;
   logic                   s0_neg_ff;
   logic [VALUE_WIDTH-1:0] s0_mag_ff;
   logic                   s0_neg_in;
   logic [VALUE_WIDTH-1:0] s0_mag_in;
   logic                   s0_rdy;

   // Binary-to-BCD stages.
   logic                   dab_valid_ff [DAB_STAGES];
   logic                   dab_hex_ff   [DAB_STAGES];
   logic                   dab_neg_ff   [DAB_STAGES];
   logic [VALUE_WIDTH-1:0] dab_raw_ff   [DAB_STAGES];
   dab_type                dab_word_ff  [DAB_STAGES];
   dab_type                dab_word_in  [DAB_STAGES];
   logic                   dab_rdy      [DAB_STAGES];

   // Output serializer.
   logic                   ser_valid_ff;
   logic                   ser_hex_ff;
   logic                   ser_minus_ff;
   logic [POS_WIDTH-1:0]   ser_pos_ff;
   digit_type              ser_digits_ff [DIGITS];
   logic                   ser_valid_in;
   logic                   ser_hex_in;
   logic                   ser_minus_in;
   logic [POS_WIDTH-1:0]   ser_pos_in;
   digit_type              ser_digits_in [DIGITS];
   logic                   ser_rdy;
   logic                   rsp_fire;
   logic [BCD_WIDTH-1:0]   final_digits;

   // Ready runs backward: a stage may load when it is empty or its
   // contents move on in the same cycle.
   always_comb begin
      ser_rdy = !ser_valid_ff || (rsp_ready && rsp_last);
      dab_rdy[DAB_STAGES-1] = !dab_valid_ff[DAB_STAGES-1] || ser_rdy;
      for (int k = DAB_STAGES - 2; k >= 0; k--) begin
         dab_rdy[k] = !dab_valid_ff[k] || dab_rdy[k+1];
      end
      s0_rdy = !s0_valid_ff || dab_rdy[0];
   end

   assign req_ready = s0_rdy;

   // Sign stage: magnitude of a negative decimal value in unsigned arithmetic,
   // which also covers the most negative value.
   always_comb begin
      s0_neg_in = (req_command == CMD_DEC) && req_value[VALUE_WIDTH-1];
      s0_mag_in = s0_neg_in ? (~req_value + 32'd1) : req_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (s0_rdy) begin
         s0_valid_ff <= req_valid;
      end
      if (s0_rdy) begin
         s0_hex_ff <= (req_command == CMD_HEX);
         s0_neg_ff <= s0_neg_in;
         s0_mag_ff <= s0_mag_in;
      end
   end

   // Each BCD stage performs a fixed slice of the double-dabble steps.
   always_comb begin
      for (int k = 0; k < DAB_STAGES; k++) begin
         if (k == 0) begin
            dab_word_in[k] = {{BCD_WIDTH{1'b0}}, s0_mag_ff};
         end else begin
            dab_word_in[k] = dab_word_ff[k-1];
         end
         for (int j = 0; j < BITS_PER_STAGE; j++) begin
            dab_word_in[k] = dabble_step(dab_word_in[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DAB_STAGES; k++) begin
         if (reset) begin
            dab_valid_ff[k] <= 1'b0;
         end else if (dab_rdy[k]) begin
            dab_valid_ff[k] <= (k == 0) ? s0_valid_ff : dab_valid_ff[k-1];
         end
         if (dab_rdy[k]) begin
            dab_word_ff[k] <= dab_word_in[k];
            if (k == 0) begin
               dab_hex_ff[k] <= s0_hex_ff;
               dab_neg_ff[k] <= s0_neg_ff;
               dab_raw_ff[k] <= s0_mag_ff;
            end else begin
               dab_hex_ff[k] <= dab_hex_ff[k-1];
               dab_neg_ff[k] <= dab_neg_ff[k-1];
               dab_raw_ff[k] <= dab_raw_ff[k-1];
            end
         end
      end
   end

   // Digits of the finished value: BCD for decimal, nibbles for hex.
   assign final_digits = dab_hex_ff[DAB_STAGES-1]
      ? {{(BCD_WIDTH - VALUE_WIDTH){1'b0}}, dab_raw_ff[DAB_STAGES-1]}
      : dab_word_ff[DAB_STAGES-1][DAB_WIDTH-1 -: BCD_WIDTH];

   assign rsp_fire = rsp_valid && rsp_ready;

   // Serializer next state: load a new value with its top significant digit,
   // or step past the character just taken.
   always_comb begin
      ser_valid_in = ser_valid_ff;
      ser_hex_in   = ser_hex_ff;
      ser_minus_in = ser_minus_ff;
      ser_pos_in   = ser_pos_ff;
      for (int i = 0; i < DIGITS; i++) begin
         ser_digits_in[i] = ser_digits_ff[i];
      end
      if (ser_rdy) begin
         ser_valid_in = dab_valid_ff[DAB_STAGES-1];
         ser_hex_in   = dab_hex_ff[DAB_STAGES-1];
         ser_minus_in = dab_neg_ff[DAB_STAGES-1];
         ser_pos_in   = '0;
         for (int i = 0; i < DIGITS; i++) begin
            ser_digits_in[i] = final_digits[4*i +: 4];
            if (final_digits[4*i +: 4] != 4'd0) begin
               ser_pos_in = POS_WIDTH'(i);
            end
         end
      end else if (rsp_fire) begin
         if (ser_minus_ff) begin
            ser_minus_in = 1'b0;
         end else begin
            ser_pos_in = ser_pos_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_valid_ff <= 1'b0;
      end else begin
         ser_valid_ff <= ser_valid_in;
      end
      ser_hex_ff   <= ser_hex_in;
      ser_minus_ff <= ser_minus_in;
      ser_pos_ff   <= ser_pos_in;
      for (int i = 0; i < DIGITS; i++) begin
         ser_digits_ff[i] <= ser_digits_in[i];
      end
   end

   // Response outputs come straight from the serializer registers.
   assign rsp_valid     = ser_valid_ff;
   assign rsp_character = ser_minus_ff ? ASCII_MINUS : digit_char(ser_digits_ff[ser_pos_ff]);
   assign rsp_last      = !ser_minus_ff && (ser_pos_ff == '0);

`include "assert_macros.svh"

   `ASSERT_SAME(a_minus_only_decimal, ser_valid_ff && ser_minus_ff, !ser_hex_ff, "minus sign on a hex value")
   `ASSERT_SAME(a_hex_pos_range, ser_valid_ff && ser_hex_ff, ser_pos_ff < POS_WIDTH'(8), "hex digit position out of range")
   `ASSERT_NEXT(a_value_continues, rsp_fire && !rsp_last, ser_valid_ff, "value ended before its last character")
   `ASSERT_NEXT(a_pos_steps_down, rsp_fire && !rsp_last && !ser_minus_ff, ser_pos_ff == $past(ser_pos_ff) - 1'b1, "digit position did not step down")

endmodule

@@ bench/tb.sv @@
module tb;
   import i2a_pkg::*;

   // ASCII codes used by the predictor.
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO   = 7'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_A = 7'h61;
   localparam logic [CHAR_WIDTH-1:0] CH_DASH   = 7'h2d;

   localparam int MAX_WAIT      = 13;
   localparam int LONG_HOLD     = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int DRAIN_CYCLES  = 30;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] character;
      logic                  last;
   } text_char_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   command_type            req_command;
   logic [VALUE_WIDTH-1:0] req_value;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [CHAR_WIDTH-1:0]  rsp_character;
   logic                   rsp_last;

   // Characters still owed by the block, oldest first.
   text_char_type pending_text[$];

   bit idle_on;
   bit hold_request;
   int error_count;
   int values_sent;
   int decimal_sent;
   int hex_sent;
   int chars_checked;
   int stall_cycles;

   integer_to_ascii_formatter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_command   (req_command),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_character (rsp_character),
      .rsp_last      (rsp_last)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   // Print one mismatch line and count it.
   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Work out the printed form of one value and queue its characters.
   function automatic void predict_text(input command_type cmd,
                                        input logic [VALUE_WIDTH-1:0] value);
      logic [VALUE_WIDTH-1:0] mag;
      logic [VALUE_WIDTH-1:0] radix;
      logic [VALUE_WIDTH-1:0] d;
      logic [CHAR_WIDTH-1:0]  text[$];
      text_char_type          item;
      mag   = value;
      radix = (cmd == CMD_DEC) ? 32'd10 : 32'd16;
      if (cmd == CMD_DEC && value[VALUE_WIDTH-1]) begin
         text.push_back(CH_DASH);
         // Unsigned negation keeps the most negative value in range.
         mag = 32'd0 - value;
      end
      if (mag == 0) begin
         text.push_back(CH_ZERO);
      end else begin
         int first;
         first = text.size();
         while (mag != 0) begin
            d = mag % radix;
            if (d < 10) begin
               text.insert(first, CH_ZERO + CHAR_WIDTH'(d));
            end else begin
               text.insert(first, CH_LOWER_A + CHAR_WIDTH'(d - 10));
            end
            mag = mag / radix;
         end
      end
      foreach (text[i]) begin
         item.character = text[i];
         item.last      = (i == text.size() - 1);
         pending_text.push_back(item);
      end
   endfunction

   // Offer one value, after a random gap if idle_on, and hold it until it is taken.
   task automatic send_value(input command_type cmd, input logic [VALUE_WIDTH-1:0] value);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_command <= cmd;
      req_value   <= value;
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_text(cmd, value);
      values_sent++;
      if (cmd == CMD_DEC) begin
         decimal_sent++;
      end else begin
         hex_sent++;
      end
   endtask

   // Random values weighted toward small, sign-boundary and power-of-two cases.
   function automatic logic [VALUE_WIDTH-1:0] random_value();
      logic [VALUE_WIDTH-1:0] v;
      case ($urandom_range(0, 5))
         0: v = $urandom();
         1: v = $urandom_range(0, 20);
         2: v = 32'd1 << $urandom_range(0, 31);
         3: v = 32'd0 - 32'($urandom_range(1, 20));
         4: v = {1'b1, 31'($urandom())};
         default: v = $urandom() >> $urandom_range(0, 31);
      endcase
      return v;
   endfunction

   function automatic command_type random_command();
      return command_type'($urandom_range(0, 1));
   endfunction

   // Compare one accepted character with the oldest expectation.
   task automatic check_character();
      text_char_type want;
      if (pending_text.size() == 0) begin
         report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                   rsp_character, rsp_last));
      end else begin
         want = pending_text.pop_front();
         if (rsp_character !== want.character) begin
            report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                      rsp_character, want.character));
         end
         if (rsp_last !== want.last) begin
            report_mismatch($sformatf("last %0b, expected %0b for character 0x%02h",
                                      rsp_last, want.last, want.character));
         end
      end
      chars_checked++;
   endtask

   // Receiver: random hold per character if idle_on, or one long hold on request.
   // It stays idle until reset is released, while the response valid is unknown.
   initial begin
      int hold;
      rsp_ready <= 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold = LONG_HOLD;
         end else begin
            hold = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         check_character();
      end
   end

   // Watchdog: too many cycles without any transaction ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // Boundary values in both formats, with random gaps on both sides.
   task automatic test_directed();
      idle_on = 1'b1;
      send_value(CMD_DEC, 32'h0000_0000);
      send_value(CMD_HEX, 32'h0000_0000);
      send_value(CMD_DEC, 32'h8000_0000);
      send_value(CMD_HEX, 32'h8000_0000);
      send_value(CMD_DEC, 32'hffff_ffff);
      send_value(CMD_HEX, 32'hffff_ffff);
      send_value(CMD_DEC, 32'h7fff_ffff);
      send_value(CMD_HEX, 32'h7fff_ffff);
      send_value(CMD_DEC, 32'd1);
      send_value(CMD_DEC, 32'd9);
      send_value(CMD_DEC, 32'd10);
      send_value(CMD_HEX, 32'd15);
      send_value(CMD_HEX, 32'd16);
      send_value(CMD_HEX, 32'h0000_000a);
      send_value(CMD_HEX, 32'hdead_beef);
      send_value(CMD_HEX, 32'hfedc_ba98);
      send_value(CMD_HEX, 32'h1234_5678);
      send_value(CMD_HEX, 32'h1000_0000);
      send_value(CMD_DEC, 32'd1000000000);
      send_value(CMD_DEC, 32'd999999999);
      send_value(CMD_DEC, 32'd0 - 32'd1000000000);
      send_value(CMD_DEC, 32'd0 - 32'd10);
   endtask

   // Random values with random gaps on both sides.
   task automatic test_random_gaps();
      idle_on = 1'b1;
      repeat (80) send_value(random_command(), random_value());
   endtask

   // Random values streamed back to back with the receiver always ready.
   task automatic test_random_streaming();
      idle_on = 1'b0;
      repeat (60) send_value(random_command(), random_value());
   endtask

   // The receiver stalls for a long stretch while values keep coming.
   task automatic test_backpressure();
      idle_on      = 1'b0;
      hold_request = 1'b1;
      repeat (20) send_value(random_command(), random_value());
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_command <= CMD_DEC;
      req_value   <= '0;
      idle_on      = 1'b0;
      hold_request = 1'b0;
      error_count  = 0;
      values_sent  = 0;
      decimal_sent = 0;
      hex_sent     = 0;
      chars_checked = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_gaps();
      test_random_streaming();
      test_backpressure();

      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d values (%0d decimal, %0d hex) and checked %0d characters,",
               values_sent, decimal_sent, hex_sent, chars_checked);
      $display("with random gaps, back-to-back streaming and one long output stall.");
      if (error_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
